// ===== sv/cfa_pkg.sv =====
// Shared constants, codes and types of the contiguous fit allocator.
package cfa_pkg;

   localparam int DEPTH = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LEN_W = ADDR_W + 1;

   localparam int COUNT_W = 11;
   localparam int FIRST_W = 10;
   localparam int METHOD_W = 2;
   localparam int BASE_W = 10;

   localparam int SUM_W = ((LEN_W > COUNT_W) ? LEN_W : COUNT_W) + 1;

   localparam int REQ_DATA_W = ((COUNT_W + FIRST_W + METHOD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BASE_W + 7) / 8) * 8;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [METHOD_W-1:0] METHOD_FIRST = 2'd0;
   localparam logic [METHOD_W-1:0] METHOD_BEST = 2'd1;
   localparam logic [METHOD_W-1:0] METHOD_WORST = 2'd2;
   localparam logic [METHOD_W-1:0] METHOD_BAD = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CLOSE,
      ST_SETUP,
      ST_MARK,
      ST_DONE
   } cfa_state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic close;
      logic setup_mark;
      logic mark_wr;
      logic rsp_push;
   } cfa_cmd_type;

   typedef struct packed {
      logic req_release;
      logic req_bad_method;
      logic scan_last;
      logic mark_done;
      logic rsp_free;
   } cfa_status_type;

endpackage

// ===== sv/contiguous_fit_allocator_core.sv =====
// Top level of the contiguous fit allocator: controller plus datapath.
//
// Allocates and releases contiguous runs in a free map of DEPTH units, all
// free after reset. One request is worked on at a time. An allocate scans the
// whole map through the map memory's single read port, one unit per cycle,
// then marks the granted units one per cycle. The result turns valid in the
// same cycle as the next request can be taken. After reset a clearing pass
// sets every unit free while req_tready stays low. The result register lets
// the next request in while a result still waits for its transfer.
module contiguous_fit_allocator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // unit_count, first_unit, fit_method, zero fill
   input  logic [cfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // base_unit, zero fill
   output logic [cfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // granted
   output logic                               rsp_tuser
);

   cfa_pkg::cfa_cmd_type    cmd;
   cfa_pkg::cfa_status_type status;
   logic [cfa_pkg::BASE_W-1:0] rsp_base;

   cfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cfa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_action  (req_tuser),
      .req_count   (req_tdata[cfa_pkg::COUNT_W-1:0]),
      .req_first   (req_tdata[cfa_pkg::COUNT_W +: cfa_pkg::FIRST_W]),
      .req_method  (req_tdata[cfa_pkg::COUNT_W + cfa_pkg::FIRST_W +: cfa_pkg::METHOD_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_granted (rsp_tuser),
      .rsp_base    (rsp_base)
   );

   assign rsp_tdata = cfa_pkg::RSP_DATA_W'(rsp_base);

endmodule

// ===== sv/cfa_ctrl.sv =====
// Controller state machine of the contiguous fit allocator.
module cfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  cfa_pkg::cfa_status_type status,
   output cfa_pkg::cfa_cmd_type    cmd
);

   cfa_pkg::cfa_state_type state_ff;
   cfa_pkg::cfa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfa_pkg::ST_CLEAR: begin
            if (status.mark_done) begin
               state_in = cfa_pkg::ST_IDLE;
            end
         end
         cfa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (status.req_release) begin
                  state_in = cfa_pkg::ST_MARK;
               end else if (status.req_bad_method) begin
                  state_in = cfa_pkg::ST_DONE;
               end else begin
                  state_in = cfa_pkg::ST_SCAN;
               end
            end
         end
         cfa_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = cfa_pkg::ST_DRAIN;
            end
         end
         cfa_pkg::ST_DRAIN: state_in = cfa_pkg::ST_CLOSE;
         cfa_pkg::ST_CLOSE: state_in = cfa_pkg::ST_SETUP;
         cfa_pkg::ST_SETUP: state_in = cfa_pkg::ST_MARK;
         cfa_pkg::ST_MARK: begin
            if (status.mark_done) begin
               state_in = cfa_pkg::ST_DONE;
            end
         end
         cfa_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               state_in = cfa_pkg::ST_IDLE;
            end
         end
         default: state_in = cfa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         cfa_pkg::ST_CLEAR: cmd.mark_wr = 1'b1;
         cfa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         cfa_pkg::ST_SCAN: cmd.scan_rd = 1'b1;
         cfa_pkg::ST_DRAIN: cmd = '0;
         cfa_pkg::ST_CLOSE: cmd.close = 1'b1;
         cfa_pkg::ST_SETUP: cmd.setup_mark = 1'b1;
         cfa_pkg::ST_MARK: cmd.mark_wr = 1'b1;
         cfa_pkg::ST_DONE: cmd.rsp_push = status.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== sv/cfa_datapath.sv =====
// Datapath of the contiguous fit allocator: free map, run scan, marking and result register.
module cfa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cfa_pkg::cfa_cmd_type                cmd,
   output cfa_pkg::cfa_status_type             status,
   input  logic                                req_action,
   input  logic [cfa_pkg::COUNT_W-1:0]         req_count,
   input  logic [cfa_pkg::FIRST_W-1:0]         req_first,
   input  logic [cfa_pkg::METHOD_W-1:0]        req_method,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_granted,
   output logic [cfa_pkg::BASE_W-1:0]          rsp_base
);

   logic free_mem [cfa_pkg::DEPTH];

   logic [cfa_pkg::COUNT_W-1:0]  need_ff;
   logic [cfa_pkg::METHOD_W-1:0] method_ff;

   logic [cfa_pkg::ADDR_W-1:0] scan_addr_ff;
   logic                       rd_valid_ff;
   logic [cfa_pkg::ADDR_W-1:0] rd_addr_ff;
   logic                       rd_data_ff;

   logic                       in_run_ff;
   logic [cfa_pkg::ADDR_W-1:0] run_start_ff;
   logic [cfa_pkg::LEN_W-1:0]  run_len_ff;
   logic                       found_ff;
   logic [cfa_pkg::ADDR_W-1:0] chosen_ff;
   logic [cfa_pkg::LEN_W-1:0]  chosen_len_ff;

   logic [cfa_pkg::LEN_W-1:0]  mark_ptr_ff;
   logic [cfa_pkg::LEN_W-1:0]  mark_end_ff;
   logic                       mark_val_ff;

   logic                       res_granted_ff;
   logic [cfa_pkg::BASE_W-1:0] res_base_ff;
   logic                       rsp_tvalid_ff;
   logic                       rsp_granted_ff;
   logic [cfa_pkg::BASE_W-1:0] rsp_base_ff;

   logic                       mem_we;
   logic                       eval_en;
   logic                       run_fits;
   logic                       take_run;
   logic [cfa_pkg::SUM_W-1:0]  rel_sum;
   logic [cfa_pkg::SUM_W-1:0]  alloc_sum;
   logic [cfa_pkg::LEN_W-1:0]  rel_end;
   logic [cfa_pkg::LEN_W-1:0]  alloc_end;

   assign status.req_release = (req_action == cfa_pkg::ACT_RELEASE);
   assign status.req_bad_method = (req_method == cfa_pkg::METHOD_BAD);
   assign status.scan_last = (scan_addr_ff == cfa_pkg::ADDR_W'(cfa_pkg::DEPTH - 1));
   assign status.mark_done = (mark_ptr_ff >= mark_end_ff);
   assign status.rsp_free = !rsp_tvalid_ff || rsp_tready;

   assign mem_we = cmd.mark_wr && !status.mark_done;

   assign rel_sum = cfa_pkg::SUM_W'(req_first) + cfa_pkg::SUM_W'(req_count);
   assign rel_end = (rel_sum > cfa_pkg::SUM_W'(cfa_pkg::DEPTH)) ?
                    cfa_pkg::LEN_W'(cfa_pkg::DEPTH) : cfa_pkg::LEN_W'(rel_sum);
   assign alloc_sum = cfa_pkg::SUM_W'(chosen_ff) + cfa_pkg::SUM_W'(need_ff);
   assign alloc_end = (alloc_sum > cfa_pkg::SUM_W'(cfa_pkg::DEPTH)) ?
                      cfa_pkg::LEN_W'(cfa_pkg::DEPTH) : cfa_pkg::LEN_W'(alloc_sum);

   assign eval_en = in_run_ff && ((rd_valid_ff && !rd_data_ff) || cmd.close);
   assign run_fits = cfa_pkg::SUM_W'(run_len_ff) >= cfa_pkg::SUM_W'(need_ff);
   assign take_run = run_fits &&
                     (!found_ff ||
                      (method_ff == cfa_pkg::METHOD_BEST && run_len_ff < chosen_len_ff) ||
                      (method_ff == cfa_pkg::METHOD_WORST && run_len_ff > chosen_len_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_mem[mark_ptr_ff[cfa_pkg::ADDR_W-1:0]] <= mark_val_ff;
      end
      if (cmd.scan_rd) begin
         rd_data_ff <= free_mem[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= scan_addr_ff;
      if (cmd.load) begin
         need_ff <= req_count;
         method_ff <= req_method;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rd_valid_ff <= 1'b0;
         in_run_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_rd;
         if (cmd.load) begin
            scan_addr_ff <= '0;
            in_run_ff <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan_rd) begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
            end
            if (cmd.close) begin
               in_run_ff <= 1'b0;
            end else if (rd_valid_ff) begin
               in_run_ff <= rd_data_ff;
            end
            if (eval_en && take_run) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff && rd_data_ff) begin
         if (in_run_ff) begin
            run_len_ff <= run_len_ff + 1'b1;
         end else begin
            run_start_ff <= rd_addr_ff;
            run_len_ff <= cfa_pkg::LEN_W'(1);
         end
      end
      if (eval_en && take_run) begin
         chosen_ff <= run_start_ff;
         chosen_len_ff <= run_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ptr_ff <= '0;
         mark_end_ff <= cfa_pkg::LEN_W'(cfa_pkg::DEPTH);
         mark_val_ff <= 1'b1;
      end else if (cmd.load && status.req_release) begin
         mark_ptr_ff <= cfa_pkg::LEN_W'(req_first);
         mark_end_ff <= rel_end;
         mark_val_ff <= 1'b1;
      end else if (cmd.setup_mark) begin
         if (found_ff) begin
            mark_ptr_ff <= cfa_pkg::LEN_W'(chosen_ff);
            mark_end_ff <= alloc_end;
         end else begin
            mark_ptr_ff <= '0;
            mark_end_ff <= '0;
         end
         mark_val_ff <= 1'b0;
      end else if (mem_we) begin
         mark_ptr_ff <= mark_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_granted_ff <= status.req_release;
         res_base_ff <= status.req_release ? cfa_pkg::BASE_W'(req_first) : '0;
      end else if (cmd.setup_mark) begin
         res_granted_ff <= found_ff;
         res_base_ff <= found_ff ? cfa_pkg::BASE_W'(chosen_ff) : '0;
      end
      if (cmd.rsp_push) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_base_ff <= res_base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.rsp_push) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_base = rsp_base_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) cmd.scan_rd |-> !mem_we)
      else $error("free map written during a scan");
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (cfa_pkg::SUM_W'(chosen_len_ff) >= cfa_pkg::SUM_W'(need_ff)))
      else $error("chosen run shorter than the request");
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_push |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result register overwritten before transfer");
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mark_end_ff <= cfa_pkg::LEN_W'(cfa_pkg::DEPTH)))
      else $error("marking beyond the free map");
`endif

endmodule
